/* rtl/fpa_pkg.sv */
// fpa_pkg: shared types, codes and constants of the fixed partition allocator
// used by every rtl file of the block; depends on nothing
`timescale 1ns / 1ps

package fpa_pkg;

   localparam int NUM_SLOTS_DEF = 8;
   localparam int SIZE_BITS_DEF = 16;

   localparam int NUM_REGS      = 8;
   localparam int REG_BITS      = 16;
   localparam int REG_IDX_BITS  = 3;
   localparam int PADDR_BITS    = 5;
   localparam int PDATA_BITS    = 32;

   localparam int MODE_BITS     = 2;
   localparam int JOB_BITS      = 16;
   localparam int TAG_BITS      = 8;
   localparam int SLOT_OUT_BITS = 3;
   localparam int LEFT_BITS     = 16;

   typedef enum logic [MODE_BITS-1:0] {
      MODE_FIRST = 2'd0,
      MODE_NEXT  = 2'd1,
      MODE_BEST  = 2'd2,
      MODE_WORST = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic fits;
      logic lt;
      logic gt;
   } cmp_flags_type;

   typedef struct packed {
      logic                     placed;
      logic [SLOT_OUT_BITS-1:0] slot;
      logic [LEFT_BITS-1:0]     leftover;
      logic [TAG_BITS-1:0]      tag_out;
   } result_type;

endpackage

/* rtl/fpa_csr.sv */
// fpa_csr: apb-style register port and partition size memory
// depends on fpa_pkg
`timescale 1ns / 1ps

module fpa_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [fpa_pkg::PADDR_BITS-1:0]   paddr,
   input  logic [fpa_pkg::PDATA_BITS-1:0]   pwdata,
   output logic [fpa_pkg::PDATA_BITS-1:0]   prdata,
   output logic                             pready,
   input  logic [fpa_pkg::REG_IDX_BITS-1:0] rd_addr,
   output logic [fpa_pkg::REG_BITS-1:0]     rd_data
);
   import fpa_pkg::*;

   logic [REG_BITS-1:0]     mem [NUM_REGS];
   logic [NUM_REGS-1:0]     valid_ff;
   logic [NUM_REGS-1:0]     valid_in;
   logic [REG_IDX_BITS-1:0] reg_idx;
   logic                    wr_en;
   logic [PDATA_BITS-1:0]   prdata_ff;
   logic [REG_BITS-1:0]     rd_data_ff;

   assign reg_idx = paddr[PADDR_BITS-1:2];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[reg_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // never-written entries read as their reset value of zero
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[reg_idx] <= pwdata[REG_BITS-1:0];
      end
      if (psel && !penable) begin
         prdata_ff <= valid_ff[reg_idx] ? PDATA_BITS'(mem[reg_idx]) : '0;
      end
      rd_data_ff <= valid_ff[rd_addr] ? mem[rd_addr] : '0;
   end

   assign prdata  = prdata_ff;
   assign rd_data = rd_data_ff;

endmodule

/* rtl/fpa_cmp_unit.sv */
// fpa_cmp_unit: shared subtract and compare unit used once per scanned slot
// depends on fpa_pkg
`timescale 1ns / 1ps

module fpa_cmp_unit #(
   parameter int SIZE_BITS = fpa_pkg::SIZE_BITS_DEF
) (
   input  logic [SIZE_BITS-1:0]   part_size,
   input  logic [SIZE_BITS-1:0]   need,
   input  logic [SIZE_BITS-1:0]   best_left,
   input  logic                   busy,
   output fpa_pkg::cmp_flags_type flags,
   output logic [SIZE_BITS-1:0]   diff
);
   import fpa_pkg::*;

   logic [SIZE_BITS:0] wide_diff;

   assign wide_diff  = {1'b0, part_size} - {1'b0, need};
   assign diff       = wide_diff[SIZE_BITS-1:0];
   // no borrow means the partition is large enough
   assign flags.fits = !busy && (part_size != '0) && !wide_diff[SIZE_BITS];
   // with both sizes at least need, ordering leftovers orders the sizes
   assign flags.lt   = diff < best_left;
   assign flags.gt   = diff > best_left;

endmodule

/* rtl/fpa_seq.sv */
// fpa_seq: scan sequencer, occupancy bits, next fit pointer and pick registers
// depends on fpa_pkg and fpa_cmp_unit
`timescale 1ns / 1ps

module fpa_seq #(
   parameter int NUM_SLOTS = fpa_pkg::NUM_SLOTS_DEF,
   parameter int SIZE_BITS = fpa_pkg::SIZE_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  fpa_pkg::mode_type                req_mode,
   input  logic [fpa_pkg::JOB_BITS-1:0]     req_job_size,
   input  logic [fpa_pkg::TAG_BITS-1:0]     req_job_tag,
   output logic [fpa_pkg::REG_IDX_BITS-1:0] rd_addr,
   input  logic [fpa_pkg::REG_BITS-1:0]     rd_data,
   output logic                             res_valid,
   output fpa_pkg::result_type              res,
   input  logic                             res_take
);
   import fpa_pkg::*;

   localparam int SLOT_BITS = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CNT_BITS  = $clog2(NUM_SLOTS + 1);
   localparam logic [CNT_BITS-1:0]  CNT_LAST  = CNT_BITS'(NUM_SLOTS);
   localparam logic [SLOT_BITS:0]   WRAP_N    = (SLOT_BITS + 1)'(NUM_SLOTS);
   localparam logic [SLOT_BITS-1:0] SLOT_LAST = SLOT_BITS'(NUM_SLOTS - 1);

   state_type              state_ff, state_in;
   mode_type               mode_ff, mode_in;
   logic [SIZE_BITS-1:0]   need_ff, need_in;
   logic [TAG_BITS-1:0]    tag_ff, tag_in;
   logic [CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic                   cmp_vld_ff, cmp_vld_in;
   logic [SLOT_BITS-1:0]   cmp_idx_ff, cmp_idx_in;
   logic                   have_ff, have_in;
   logic [SLOT_BITS-1:0]   pick_ff, pick_in;
   logic [SIZE_BITS-1:0]   best_ff, best_in;
   logic [NUM_SLOTS-1:0]   busy_ff, busy_in;
   logic [SLOT_BITS-1:0]   next_ff, next_in;

   logic                   accept;
   logic                   issue;
   logic [SLOT_BITS:0]     wrap_sum;
   logic [SLOT_BITS-1:0]   issue_idx;
   logic [31:0]            job_wide;
   logic [31:0]            size_wide;
   logic [31:0]            left_wide;
   logic [SIZE_BITS-1:0]   cur_size;
   cmp_flags_type          flags;
   logic [SIZE_BITS-1:0]   diff;
   logic                   seq_mode;
   logic                   take;
   logic                   hit_stop;

   assign job_wide  = 32'(req_job_size);
   assign size_wide = 32'(rd_data);
   assign cur_size  = size_wide[SIZE_BITS-1:0];
   assign seq_mode  = (mode_ff == MODE_FIRST) || (mode_ff == MODE_NEXT);

   // slot to read this cycle, rotated by the pointer for next fit
   assign wrap_sum  = {1'b0, next_ff} + {1'b0, cnt_ff[SLOT_BITS-1:0]};
   always_comb begin
      if (mode_ff == MODE_NEXT) begin
         issue_idx = (wrap_sum >= WRAP_N) ? SLOT_BITS'(wrap_sum - WRAP_N)
                                          : wrap_sum[SLOT_BITS-1:0];
      end else begin
         issue_idx = cnt_ff[SLOT_BITS-1:0];
      end
   end
   assign rd_addr = REG_IDX_BITS'(issue_idx);

   fpa_cmp_unit #(
      .SIZE_BITS (SIZE_BITS)
   ) u_cmp (
      .part_size (cur_size),
      .need      (need_ff),
      .best_left (best_ff),
      .busy      (busy_ff[cmp_idx_ff]),
      .flags     (flags),
      .diff      (diff)
   );

   always_comb begin
      take = 1'b0;
      if (cmp_vld_ff && flags.fits) begin
         unique case (mode_ff)
            MODE_FIRST, MODE_NEXT: take = 1'b1;
            MODE_BEST:             take = !have_ff || flags.lt;
            MODE_WORST:            take = !have_ff || flags.gt;
         endcase
      end
   end
   assign hit_stop = take && seq_mode;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (hit_stop || (cnt_ff == CNT_LAST)) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (res_take) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_ready  = (state_ff == ST_IDLE);
      res_valid  = (state_ff == ST_DONE);
      accept     = req_ready && req_valid;
      issue      = (state_ff == ST_SCAN) && (cnt_ff != CNT_LAST);
      left_wide  = 32'(best_ff);

      mode_in    = mode_ff;
      need_in    = need_ff;
      tag_in     = tag_ff;
      cnt_in     = cnt_ff;
      // an early stop drops the read already in flight
      cmp_vld_in = issue && !hit_stop;
      cmp_idx_in = issue_idx;
      have_in    = have_ff;
      pick_in    = pick_ff;
      best_in    = best_ff;
      busy_in    = busy_ff;
      next_in    = next_ff;

      if (accept) begin
         mode_in    = req_mode;
         need_in    = job_wide[SIZE_BITS-1:0];
         tag_in     = req_job_tag;
         cnt_in     = '0;
         cmp_vld_in = 1'b0;
         have_in    = 1'b0;
      end
      if (issue) begin
         cnt_in = cnt_ff + 1'b1;
      end
      if ((state_ff == ST_SCAN) && take) begin
         have_in = 1'b1;
         pick_in = cmp_idx_ff;
         best_in = diff;
      end
      if (res_valid && res_take && have_ff) begin
         busy_in[pick_ff] = 1'b1;
         if (mode_ff == MODE_NEXT) begin
            next_in = (pick_ff == SLOT_LAST) ? '0 : pick_ff + 1'b1;
         end
      end

      res.placed   = have_ff;
      res.slot     = have_ff ? SLOT_OUT_BITS'(pick_ff) : '0;
      res.leftover = have_ff ? left_wide[LEFT_BITS-1:0] : '0;
      res.tag_out  = tag_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cnt_ff     <= '0;
         cmp_vld_ff <= 1'b0;
         have_ff    <= 1'b0;
         busy_ff    <= '0;
         next_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         cmp_vld_ff <= cmp_vld_in;
         have_ff    <= have_in;
         busy_ff    <= busy_in;
         next_ff    <= next_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff    <= mode_in;
      need_ff    <= need_in;
      tag_ff     <= tag_in;
      cmp_idx_ff <= cmp_idx_in;
      pick_ff    <= pick_in;
      best_ff    <= best_in;
   end

`ifndef SYNTH
   // a held pick always names a partition that is still free
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE && have_ff) |-> !busy_ff[pick_ff])
      else $error("picked partition already busy");

   // the next fit pointer never leaves the slot range
   assert property (@(posedge clock) disable iff (reset)
      next_ff <= SLOT_LAST)
      else $error("next fit pointer out of range");

   // a result that is not taken holds its pick
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && !res_take) |=>
         (state_ff == ST_DONE && $stable(pick_ff) && $stable(have_ff)))
      else $error("pending result changed");

   // compares only happen while scanning
   assert property (@(posedge clock) disable iff (reset)
      cmp_vld_ff |-> (state_ff == ST_SCAN))
      else $error("compare outside scan");
`endif

endmodule

/* rtl/fixed_partition_allocator.sv */
// fixed_partition_allocator: top level with request/response channels and csr port
// depends on fpa_pkg, fpa_csr, fpa_seq (and through it fpa_cmp_unit)
`timescale 1ns / 1ps

// Places each request transaction into one of NUM_SLOTS fixed partitions whose
// sizes are written through the apb-style port (part_size_i at byte address 4*i,
// 16 bits, zero marks a partition unusable). The mode field selects first, next,
// best or worst fit; best and worst fit pick the lowest index on a tie. A placed
// partition stays busy until reset, and next fit keeps its pointer between
// transactions. Each request gives exactly one response transaction. Timing:
// one request is in flight at a time; a full scan runs from acceptance to the
// response register, while first and next fit stop at the first match and
// finish sooner. The next request can be taken in the cycle after the response
// is loaded. The scan reads one partition size per cycle from the size memory
// and checks it in the single shared subtract/compare unit. The response sits
// in an output register, so a new request is taken while the previous
// response waits.

module fixed_partition_allocator #(
   parameter int NUM_SLOTS = fpa_pkg::NUM_SLOTS_DEF,
   parameter int SIZE_BITS = fpa_pkg::SIZE_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [fpa_pkg::MODE_BITS-1:0]       req_mode,
   input  logic [fpa_pkg::JOB_BITS-1:0]        req_job_size,
   input  logic [fpa_pkg::TAG_BITS-1:0]        req_job_tag,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_placed,
   output logic [fpa_pkg::SLOT_OUT_BITS-1:0]   rsp_slot,
   output logic [fpa_pkg::LEFT_BITS-1:0]       rsp_leftover,
   output logic [fpa_pkg::TAG_BITS-1:0]        rsp_tag_out,
   // configuration port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [fpa_pkg::PADDR_BITS-1:0]      paddr,
   input  logic [fpa_pkg::PDATA_BITS-1:0]      pwdata,
   output logic [fpa_pkg::PDATA_BITS-1:0]      prdata,
   output logic                                pready
);
   import fpa_pkg::*;

   logic [REG_IDX_BITS-1:0] rd_addr;
   logic [REG_BITS-1:0]     rd_data;
   logic                    res_valid;
   result_type              res;
   logic                    res_take;
   logic                    load;

   // output register state
   logic                    rsp_valid_ff, rsp_valid_in;
   result_type              rsp_ff;

   // size memory; the user must write it only while no transaction is in flight, the block does not enforce this
   fpa_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // scan sequencer with the shared compare unit inside
   fpa_seq #(
      .NUM_SLOTS (NUM_SLOTS),
      .SIZE_BITS (SIZE_BITS)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_mode     (mode_type'(req_mode)),
      .req_job_size (req_job_size),
      .req_job_tag  (req_job_tag),
      .rd_addr      (rd_addr),
      .rd_data      (rd_data),
      .res_valid    (res_valid),
      .res          (res),
      .res_take     (res_take)
   );

   // the register frees up when empty or drained in this cycle
   assign res_take = !rsp_valid_ff || rsp_ready;
   assign load     = res_valid && res_take;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload holds until the next load
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_placed   = rsp_ff.placed;
   assign rsp_slot     = rsp_ff.slot;
   assign rsp_leftover = rsp_ff.leftover;
   assign rsp_tag_out  = rsp_ff.tag_out;

endmodule

/* dv/tb_fixed_partition_allocator.sv */
// tb_fixed_partition_allocator: self-checking testbench for the fixed partition allocator
// depends on fpa_pkg and fixed_partition_allocator from the rtl folder
`timescale 1ns / 1ps

module tb_fixed_partition_allocator;
   import fpa_pkg::*;

   localparam int SLOTS          = NUM_SLOTS_DEF;
   localparam int STALL_LIMIT    = 2000;  // cycles with no transaction on any port
   localparam int RAND_PHASES    = 5;
   localparam int JOBS_PER_PHASE = 150;

   // tracks partition sizes, occupancy and the next fit pointer, and holds the
   // responses that accepted requests are owed, oldest first
   class partition_tracker;
      bit [REG_BITS-1:0] part_size [SLOTS];
      bit                busy [SLOTS];
      int unsigned       next_ptr;
      result_type        owed_results [$];
      int                errors;

      function void set_size(int idx, bit [REG_BITS-1:0] val);
         part_size[idx] = val;
      endfunction

      function bit fits(int idx, bit [JOB_BITS-1:0] need);
         return !busy[idx] && part_size[idx] != 0 && part_size[idx] >= need;
      endfunction

      // work out the placement of one accepted request and update occupancy
      function void note_job(mode_type mode, bit [JOB_BITS-1:0] need, bit [TAG_BITS-1:0] tag);
         int         pick;
         int         k;
         result_type r;
         pick = -1;
         case (mode)
            MODE_FIRST: begin
               for (int i = 0; i < SLOTS; i++)
                  if (pick < 0 && fits(i, need)) pick = i;
            end
            MODE_NEXT: begin
               for (int i = 0; i < SLOTS; i++) begin
                  k = (next_ptr + i) % SLOTS;
                  if (pick < 0 && fits(k, need)) pick = k;
               end
            end
            default: begin
               // best and worst fit: strict compare keeps the lowest index on a tie
               for (int i = 0; i < SLOTS; i++) begin
                  if (fits(i, need)) begin
                     if (pick < 0)
                        pick = i;
                     else if ((mode == MODE_BEST  && part_size[i] < part_size[pick]) ||
                              (mode == MODE_WORST && part_size[i] > part_size[pick]))
                        pick = i;
                  end
               end
            end
         endcase
         r = '0;
         r.tag_out = tag;
         if (pick >= 0) begin
            busy[pick] = 1'b1;
            if (mode == MODE_NEXT) next_ptr = (pick + 1) % SLOTS;
            r.placed   = 1'b1;
            r.slot     = pick[SLOT_OUT_BITS-1:0];
            r.leftover = part_size[pick] - need;
         end
         owed_results.push_back(r);
      endfunction

      function void cmp_field(string what, int unsigned want, int unsigned got);
         if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            errors++;
         end
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (owed_results.size() == 0) begin
            $display("%0t: response with no request pending, actual tag %0d",
                     $time, got.tag_out);
            errors++;
            return;
         end
         want = owed_results.pop_front();
         cmp_field("placed",   32'(want.placed),   32'(got.placed));
         cmp_field("slot",     32'(want.slot),     32'(got.slot));
         cmp_field("leftover", 32'(want.leftover), 32'(got.leftover));
         cmp_field("tag_out",  32'(want.tag_out),  32'(got.tag_out));
      endfunction
   endclass

   // every input starts at a known value
   logic                     clock        = 1'b0;
   logic                     reset        = 1'b1;
   logic                     req_valid    = 1'b0;
   logic [MODE_BITS-1:0]     req_mode     = '0;
   logic [JOB_BITS-1:0]      req_job_size = '0;
   logic [TAG_BITS-1:0]      req_job_tag  = '0;
   logic                     rsp_ready    = 1'b0;
   logic                     psel         = 1'b0;
   logic                     penable      = 1'b0;
   logic                     pwrite       = 1'b0;
   logic [PADDR_BITS-1:0]    paddr        = '0;
   logic [PDATA_BITS-1:0]    pwdata       = '0;

   logic                     req_ready;
   logic                     rsp_valid;
   logic                     rsp_placed;
   logic [SLOT_OUT_BITS-1:0] rsp_slot;
   logic [LEFT_BITS-1:0]     rsp_leftover;
   logic [TAG_BITS-1:0]      rsp_tag_out;
   logic [PDATA_BITS-1:0]    prdata;
   logic                     pready;

   partition_tracker  sb;
   int                idle_pct = 0;     // chance of an idle burst, per phase
   int                rx_hold  = 0;     // remaining stall cycles on the response side
   int                quiet_cycles = 0;
   logic [REG_BITS-1:0] plan_size [SLOTS];

   fixed_partition_allocator dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_mode     (req_mode),
      .req_job_size (req_job_size),
      .req_job_tag  (req_job_tag),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_placed   (rsp_placed),
      .rsp_slot     (rsp_slot),
      .rsp_leftover (rsp_leftover),
      .rsp_tag_out  (rsp_tag_out),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // response side: ready is dropped at random while idling is on
   always @(posedge clock) begin
      if (rx_hold > 0) begin
         rx_hold   <= rx_hold - 1;
         rsp_ready <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         rx_hold   <= $urandom_range(0, 15);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // every response transaction is checked against the oldest owed result
   always @(posedge clock) begin
      result_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.placed   = rsp_placed;
         got.slot     = rsp_slot;
         got.leftover = rsp_leftover;
         got.tag_out  = rsp_tag_out;
         sb.check_result(got);
      end
   end

   // watchdog: too long with no transaction anywhere means a hang
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // one request transaction; returns at the edge where it was accepted,
   // leaving valid high so a following request can go out back to back
   task automatic send_job(mode_type mode, logic [JOB_BITS-1:0] need,
                           logic [TAG_BITS-1:0] tag);
      req_valid    <= 1'b1;
      req_mode     <= mode;
      req_job_size <= need;
      req_job_tag  <= tag;
      do @(posedge clock); while (!req_ready);
      sb.note_job(mode, need, tag);
   endtask

   task automatic idle_gap();
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clock);
   endtask

   // hold off requests until every owed response has come back
   task automatic drain_all();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.owed_results.size() != 0);
      repeat (2) @(posedge clock);
   endtask

   // one csr write: setup then access; psel stays up for a following write
   task automatic write_part_size(int idx, logic [REG_BITS-1:0] val);
      logic [PADDR_BITS-1:0] addr;
      logic [PDATA_BITS-1:0] word;
      addr = PADDR_BITS'(idx * 4);
      word = $urandom;                  // upper bits are don't care, keep them busy
      word[REG_BITS-1:0] = val;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= word;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.set_size(idx, val);
   endtask

   // write all eight partition sizes from plan_size; block must be idle
   task automatic apply_sizes();
      for (int i = 0; i < SLOTS; i++) write_part_size(i, plan_size[i]);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   initial begin
      logic [MODE_BITS-1:0] mb;
      logic [JOB_BITS-1:0]  need;
      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // sizes still at reset: every partition unusable, nothing can be placed,
      // including a zero size job
      send_job(MODE_FIRST, 16'h0000, 8'h00);
      send_job(MODE_NEXT,  16'hFFFF, 8'hFF);
      send_job(MODE_BEST,  16'h0001, 8'h55);
      send_job(MODE_WORST, 16'h8000, 8'hAA);
      drain_all();

      // four usable partitions, the rest kept at zero for later phases
      idle_pct = 25;
      plan_size = '{16'd100, 16'd50, 16'd50, 16'd200, 16'd0, 16'd0, 16'd0, 16'd0};
      apply_sizes();
      send_job(MODE_BEST,  16'd50, 8'h01);   // tie between 1 and 2, lower index wins
      send_job(MODE_WORST, 16'd10, 8'h02);   // largest free partition
      send_job(MODE_NEXT,  16'd1,  8'h03);   // pointer starts at zero
      idle_gap();
      send_job(MODE_FIRST, 16'd51, 8'h04);   // only the 50 left free, too small
      send_job(MODE_FIRST, 16'd0,  8'h05);   // zero job fits any free nonzero partition
      send_job(MODE_BEST,  16'd1,  8'h06);   // all usable partitions now busy
      drain_all();

      // two equal maximum partitions, next fit scanning past busy ones
      plan_size[4] = 16'hFFFF;
      plan_size[5] = 16'hFFFF;
      apply_sizes();
      send_job(MODE_WORST, 16'd1,    8'h07); // tie on largest size, lower index wins
      send_job(MODE_NEXT,  16'd1,    8'h08); // pointer skips busy slots to the last free
      send_job(MODE_NEXT,  16'd5,    8'h09); // full wrap with no match keeps the pointer
      send_job(MODE_FIRST, 16'hFFFF, 8'h0A);
      send_job(MODE_WORST, 16'hFFFF, 8'h0B);
      drain_all();

      // random phases: fresh sizes each time (zeros, ones, maximum, repeats for
      // ties), random modes and job sizes mostly near the partition sizes
      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         case (ph)
            0:       idle_pct = 30;
            1:       idle_pct = 0;    // a stretch with no idling at all
            2:       idle_pct = 50;
            3:       idle_pct = 20;
            default: idle_pct = 0;    // no idling toward the end of the run
         endcase
         for (int i = 0; i < SLOTS; i++) begin
            case ($urandom_range(0, 5))
               0:       plan_size[i] = 16'd0;
               1:       plan_size[i] = 16'd1;
               2:       plan_size[i] = 16'hFFFF;
               3:       plan_size[i] = REG_BITS'($urandom);
               default: plan_size[i] = 16'd64 << $urandom_range(0, 2);
            endcase
         end
         apply_sizes();
         for (int n = 0; n < JOBS_PER_PHASE; n++) begin
            mb = MODE_BITS'($urandom_range(0, 3));
            case ($urandom_range(0, 5))
               0:       need = 16'd0;
               1:       need = 16'hFFFF;
               2:       need = JOB_BITS'($urandom);
               default: need = JOB_BITS'($urandom_range(1, 300));
            endcase
            send_job(mode_type'(mb), need, TAG_BITS'($urandom_range(0, 255)));
            if ($urandom_range(0, 49) == 0)
               drain_all();
            else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
               idle_gap();
         end
         drain_all();
      end

      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.owed_results.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
